### rtl/core/u8sd_pkg.sv
`timescale 1ns / 1ps

package u8sd_pkg;

  // Field widths of the byte and result items
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 3;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_CHAR   = 3'd0,
    ST_EOS    = 3'd1,
    ST_STRAY  = 3'd2,
    ST_BROKEN = 3'd3,
    ST_BADLEAD = 3'd4
  } status_e;

  // Lead byte prefixes and masks
  localparam logic [ByteW-1:0] MaskC0  = 8'hC0;
  localparam logic [ByteW-1:0] MaskE0  = 8'hE0;
  localparam logic [ByteW-1:0] MaskF0  = 8'hF0;
  localparam logic [ByteW-1:0] MaskF8  = 8'hF8;
  localparam logic [ByteW-1:0] MaskFC  = 8'hFC;
  localparam logic [ByteW-1:0] MaskFE  = 8'hFE;
  localparam logic [ByteW-1:0] PfxCont = 8'h80;
  localparam logic [ByteW-1:0] PfxLen2 = 8'hC0;
  localparam logic [ByteW-1:0] PfxLen3 = 8'hE0;
  localparam logic [ByteW-1:0] PfxLen4 = 8'hF0;
  localparam logic [ByteW-1:0] PfxLen5 = 8'hF8;
  localparam logic [ByteW-1:0] PfxLen6 = 8'hFC;
  localparam logic [ByteW-1:0] PfxLen7 = 8'hFE;

endpackage

### rtl/core/u8sd_byte_if.sv
`timescale 1ns / 1ps

interface u8sd_byte_if
  import u8sd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             string_start;

  modport source (output valid, output data_byte, output string_start, input ready);
  modport sink   (input valid, input data_byte, input string_start, output ready);
endinterface

### rtl/core/u8sd_char_if.sv
`timescale 1ns / 1ps

interface u8sd_char_if
  import u8sd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CpW-1:0]     code_point;
  logic [StatusW-1:0] status;
  logic [LenW-1:0]    seq_length;

  modport source (output valid, output code_point, output status, output seq_length,
                  input ready);
  modport sink   (input valid, input code_point, input status, input seq_length,
                  output ready);
endinterface

### rtl/core/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Extended UTF-8 byte stream decoder. One byte item enters per cycle; each byte
// passes an input register, one step of decode logic and a result register, so
// a result leaves the result register once its last byte is decoded, and the block
// sustains one byte per cycle as long as the result side keeps taking items.
// Lead bytes open sequences of 1 to 7 octets (0xFE opens seven, keeping only
// the low 32 bits of the value). Completed characters report code point and
// length; NUL reports end of string; a stray continuation, a broken sequence or
// the lead 0xFF report an error. After any of those the decoder drops bytes
// until one arrives with string_start set, which also discards an open
// sequence. Bytes that only extend a sequence produce no result item.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  u8sd_byte_if.sink   in_i,
  u8sd_char_if.source out_o
);

  // Input register
  logic             stg_valid_q;
  logic [ByteW-1:0] stg_byte_q;
  logic             stg_start_q;

  // Decoder state
  logic             stopped_q, stopped_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [LenW-1:0]  open_len_q, open_len_d;
  logic [CpW-1:0]   acc_q, acc_d;

  // Result register
  logic               out_valid_q;
  logic [CpW-1:0]     cp_q;
  logic [StatusW-1:0] status_q;
  logic [LenW-1:0]    len_q;

  logic               out_free;
  logic               adv;
  logic               res_vld;
  logic [CpW-1:0]     res_cp;
  status_e            res_status;
  logic [LenW-1:0]    res_len;

  logic             eff_stopped;
  logic [LenW-1:0]  eff_left;
  logic [LenW-1:0]  eff_len;
  logic [CpW-1:0]   eff_acc;
  logic [ByteW-1:0] b;

  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = stg_valid_q && out_free;
  assign in_i.ready = !stg_valid_q || out_free;

  assign b = stg_byte_q;

  // Apply string start before decoding the byte
  assign eff_stopped = stopped_q && !stg_start_q;
  assign eff_left    = stg_start_q ? '0 : left_q;
  assign eff_len     = stg_start_q ? '0 : open_len_q;
  assign eff_acc     = stg_start_q ? '0 : acc_q;

  // Decode one byte against the current state
  always_comb begin
    stopped_d  = eff_stopped;
    left_d     = eff_left;
    open_len_d = eff_len;
    acc_d      = eff_acc;
    res_vld    = 1'b0;
    res_cp     = '0;
    res_status = ST_CHAR;
    res_len    = LenW'(1);
    if (eff_stopped) begin
      res_vld = 1'b0;
    end else if (eff_left != '0) begin
      if ((b & MaskC0) == PfxCont) begin
        acc_d  = {eff_acc[CpW-7:0], b[5:0]};
        left_d = eff_left - LenW'(1);
        if (eff_left == LenW'(1)) begin
          res_vld = 1'b1;
          res_cp  = acc_d;
          res_len = eff_len;
        end
      end else begin
        left_d     = '0;
        stopped_d  = 1'b1;
        res_vld    = 1'b1;
        res_status = ST_BROKEN;
        res_len    = eff_len;
      end
    end else begin
      priority if (b == '0) begin
        stopped_d  = 1'b1;
        res_vld    = 1'b1;
        res_status = ST_EOS;
      end else if (!b[7]) begin
        res_vld = 1'b1;
        res_cp  = {{(CpW-ByteW){1'b0}}, b};
      end else if ((b & MaskC0) == PfxCont) begin
        stopped_d  = 1'b1;
        res_vld    = 1'b1;
        res_status = ST_STRAY;
      end else if ((b & MaskE0) == PfxLen2) begin
        open_len_d = LenW'(2);
        left_d     = LenW'(1);
        acc_d      = {{(CpW-5){1'b0}}, b[4:0]};
      end else if ((b & MaskF0) == PfxLen3) begin
        open_len_d = LenW'(3);
        left_d     = LenW'(2);
        acc_d      = {{(CpW-4){1'b0}}, b[3:0]};
      end else if ((b & MaskF8) == PfxLen4) begin
        open_len_d = LenW'(4);
        left_d     = LenW'(3);
        acc_d      = {{(CpW-3){1'b0}}, b[2:0]};
      end else if ((b & MaskFC) == PfxLen5) begin
        open_len_d = LenW'(5);
        left_d     = LenW'(4);
        acc_d      = {{(CpW-2){1'b0}}, b[1:0]};
      end else if ((b & MaskFE) == PfxLen6) begin
        open_len_d = LenW'(6);
        left_d     = LenW'(5);
        acc_d      = {{(CpW-1){1'b0}}, b[0]};
      end else if (b == PfxLen7) begin
        open_len_d = LenW'(7);
        left_d     = LenW'(6);
        acc_d      = '0;
      end else begin
        stopped_d  = 1'b1;
        res_vld    = 1'b1;
        res_status = ST_BADLEAD;
      end
    end
  end

  // Capture incoming byte items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_byte_q  <= in_i.data_byte;
      stg_start_q <= in_i.string_start;
    end
  end

  // Advance decoder state once per decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q  <= 1'b0;
      left_q     <= '0;
      open_len_q <= '0;
      acc_q      <= '0;
    end else if (adv) begin
      stopped_q  <= stopped_d;
      left_q     <= left_d;
      open_len_q <= open_len_d;
      acc_q      <= acc_d;
    end
  end

  // Hold result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      cp_q     <= res_cp;
      status_q <= res_status;
      len_q    <= res_len;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = cp_q;
  assign out_o.status     = status_q;
  assign out_o.seq_length = len_q;

endmodule

### verif/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8sd_pkg::*;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned ByteTarget   = 1950;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned CycleLimit   = 1_000_000;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             string_start;
    logic             drain;
  } byte_item_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    status_e         status;
    logic [LenW-1:0] seq_length;
  } char_item_t;

  logic clk_i;
  logic rst_ni;

  u8sd_byte_if byte_bus ();
  u8sd_char_if char_bus ();

  utf8_stream_decoder i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_bus),
    .out_o (char_bus)
  );

  // Bytes waiting to be sent and characters waiting to arrive
  byte_item_t  byte_q[$];
  char_item_t  char_q[$];

  // Decoder state mirrored by the predictor
  logic             dec_stopped = 1'b0;
  logic [LenW-1:0]  dec_left    = '0;
  logic [LenW-1:0]  dec_len     = '0;
  logic [CpW-1:0]   dec_acc     = '0;

  // Stimulus build flags and run statistics
  logic        next_start = 1'b0;
  logic        next_drain = 1'b0;
  int unsigned counted    = 0;
  int unsigned errors     = 0;
  int unsigned sent       = 0;
  int unsigned n_char     = 0;
  int unsigned n_eos      = 0;
  int unsigned n_fault    = 0;
  logic [7:0]  len_seen   = '0;
  longint unsigned cycles = 0;

  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm  = 0;

  // Decode one byte; return 1 when it yields a character or a status item
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic start,
                                     output char_item_t res);
    int unsigned lead_len;
    logic [ByteW-1:0] pay_mask;
    res.code_point = '0;
    res.status     = ST_CHAR;
    res.seq_length = LenW'(1);
    if (start) begin
      dec_stopped = 1'b0;
      dec_left    = '0;
      dec_len     = '0;
      dec_acc     = '0;
    end
    if (dec_stopped) return 1'b0;

    // Extend or break the open sequence
    if (dec_left != 0) begin
      if ((b & MaskC0) == PfxCont) begin
        dec_acc  = {dec_acc[CpW-7:0], b[5:0]};
        dec_left = dec_left - 1'b1;
        if (dec_left != 0) return 1'b0;
        res.code_point = dec_acc;
        res.seq_length = dec_len;
        return 1'b1;
      end
      dec_left       = '0;
      dec_stopped    = 1'b1;
      res.status     = ST_BROKEN;
      res.seq_length = dec_len;
      return 1'b1;
    end

    if (b == '0) begin
      dec_stopped = 1'b1;
      res.status  = ST_EOS;
      return 1'b1;
    end
    if (!b[7]) begin
      res.code_point = CpW'(b);
      return 1'b1;
    end
    if ((b & MaskC0) == PfxCont) begin
      dec_stopped = 1'b1;
      res.status  = ST_STRAY;
      return 1'b1;
    end

    // Open a multi-octet sequence from its lead
    casez (b)
      8'b110?????: lead_len = 2;
      8'b1110????: lead_len = 3;
      8'b11110???: lead_len = 4;
      8'b111110??: lead_len = 5;
      8'b1111110?: lead_len = 6;
      8'b11111110: lead_len = 7;
      default:     lead_len = 0;
    endcase
    if (lead_len == 0) begin
      dec_stopped = 1'b1;
      res.status  = ST_BADLEAD;
      return 1'b1;
    end
    pay_mask = 8'hFF >> (lead_len + 1);
    dec_len  = LenW'(lead_len);
    dec_left = LenW'(lead_len - 1);
    dec_acc  = CpW'(b & pay_mask);
    return 1'b0;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_byte(input logic [ByteW-1:0] b, input bit count_it);
    byte_item_t it;
    it.data_byte    = b;
    it.string_start = next_start;
    it.drain        = next_drain;
    byte_q.push_back(it);
    next_start = 1'b0;
    next_drain = 1'b0;
    if (count_it) counted++;
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    logic [ByteW-1:0] r;
    r = ByteW'($urandom_range(0, 63));
    return PfxCont | r;
  endfunction

  function automatic logic [ByteW-1:0] lead_byte(input int unsigned len);
    logic [ByteW-1:0] m;
    logic [ByteW-1:0] r;
    if (len == 1) return ByteW'($urandom_range(1, 127));
    m = 8'hFF >> len;
    r = ByteW'($urandom_range(0, 255));
    return ~m | (r & (m >> 1));
  endfunction

  function automatic int unsigned pick_len(input int unsigned lo);
    if (lo <= 1 && $urandom_range(0, 99) < 35) return 1;
    return $urandom_range(2, 7);
  endfunction

  // Well-formed character with random payload
  function automatic void push_char(input int unsigned len);
    push_byte(lead_byte(len), 1'b1);
    for (int unsigned i = 1; i < len; i++) push_byte(cont_byte(), 1'b1);
  endfunction

  // Random filler bytes that are not counted; after a stop the decoder drops them
  function automatic void push_ignored();
    int unsigned n;
    n = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++) push_byte(ByteW'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void build_directed();
    // Two ASCII bytes, then a two-octet and a seven-octet character cut to 32 bits
    next_start = 1'b1;
    push_byte(8'h41, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hC3, 1'b1);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hFE, 1'b1);
    for (int i = 0; i < 6; i++) push_byte(8'hBF, 1'b1);
    // End of string, then a byte dropped while stopped
    push_byte(8'h00, 1'b1);
    push_byte(8'h41, 1'b0);
    // Stray continuation after a full drain of results
    next_start = 1'b1;
    next_drain = 1'b1;
    push_byte(8'h80, 1'b1);
    next_start = 1'b1;
    push_byte(8'hFF, 1'b1);
    // Broken sequence by an ASCII byte and by a NUL
    next_start = 1'b1;
    push_byte(8'hE2, 1'b1);
    push_byte(8'h82, 1'b1);
    push_byte(8'h41, 1'b1);
    next_start = 1'b1;
    push_byte(8'hF0, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b1);
    // Restart in the middle of an open sequence
    next_start = 1'b1;
    push_byte(8'hC2, 1'b1);
    next_start = 1'b1;
    push_byte(8'hC2, 1'b1);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h00, 1'b1);
  endfunction

  function automatic void build_random();
    int unsigned kind;
    int unsigned nchar;
    int unsigned len;
    int unsigned keep;
    logic [ByteW-1:0] r;
    while (counted < ByteTarget) begin
      kind       = $urandom_range(0, 99);
      next_start = 1'b1;
      next_drain = ($urandom_range(0, 149) == 0);
      if (kind < 75) begin
        // Clean string, ended by NUL or by the next string start
        nchar = $urandom_range(1, 8);
        for (int unsigned i = 0; i < nchar; i++) push_char(pick_len(1));
        if ($urandom_range(0, 99) < 60) begin
          push_byte(8'h00, 1'b1);
          push_ignored();
        end
      end else if (kind < 90) begin
        // Valid prefix, then a fault
        nchar = $urandom_range(0, 3);
        for (int unsigned i = 0; i < nchar; i++) push_char(pick_len(1));
        case ($urandom_range(0, 3))
          0: push_byte(cont_byte(), 1'b1);
          1: push_byte(8'hFF, 1'b1);
          2: begin
            len  = pick_len(2);
            keep = $urandom_range(0, len - 2);
            push_byte(lead_byte(len), 1'b1);
            for (int unsigned i = 0; i < keep; i++) push_byte(cont_byte(), 1'b1);
            r = ByteW'($urandom_range(0, 191));
            if (r[7]) r = r | MaskC0;
            push_byte(r, 1'b1);
          end
          default: begin
            // Left open: the next string start discards it
            len  = pick_len(2);
            keep = $urandom_range(0, len - 2);
            push_byte(lead_byte(len), 1'b1);
            for (int unsigned i = 0; i < keep; i++) push_byte(cont_byte(), 1'b1);
          end
        endcase
        push_ignored();
      end else begin
        // Raw noise
        nchar = $urandom_range(1, 12);
        for (int unsigned i = 0; i < nchar; i++) begin
          push_byte(ByteW'($urandom_range(0, 255)), 1'b1);
        end
      end
    end
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Byte driver: predict on each accepted item, then present the next one
  always @(posedge clk_i) begin : drive_bytes
    logic       nv;
    byte_item_t it;
    char_item_t res;
    if (rst_ni) begin
      nv = byte_bus.valid;
      if (byte_bus.valid && byte_bus.ready) begin
        if (decode_byte(byte_bus.data_byte, byte_bus.string_start, res)) char_q.push_back(res);
        sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && char_q.size() > 0)) begin
          it = byte_q.pop_front();
          byte_bus.data_byte    <= it.data_byte;
          byte_bus.string_start <= it.string_start;
          nv = 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(30, 120);
          end
        end
      end
      byte_bus.valid <= nv;
    end
  end

  // Result monitor: check each accepted item, then stall at random
  always @(posedge clk_i) begin : watch_chars
    logic       nr;
    char_item_t want;
    if (rst_ni) begin
      if (char_bus.valid && char_bus.ready) begin
        if (char_q.size() == 0) begin
          $error("unexpected result: code_point %0h status %0d seq_length %0d",
                 char_bus.code_point, char_bus.status, char_bus.seq_length);
          errors++;
        end else begin
          want = char_q.pop_front();
          if (char_bus.code_point !== want.code_point) begin
            $error("code_point: expected %0h, got %0h", want.code_point, char_bus.code_point);
            errors++;
          end
          if (char_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, char_bus.status);
            errors++;
          end
          if (char_bus.seq_length !== want.seq_length) begin
            $error("seq_length: expected %0d, got %0d", want.seq_length, char_bus.seq_length);
            errors++;
          end
          case (want.status)
            ST_CHAR: begin
              n_char++;
              len_seen[want.seq_length] = 1'b1;
            end
            ST_EOS:  n_eos++;
            default: n_fault++;
          endcase
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = idle_len();
          if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(30, 120);
        end
      end
      char_bus.ready <= nr;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL utf8_stream_decoder");
      $finish;
    end
  end

  // Reset, stimulus build and end of run
  initial begin
    rst_ni                = 1'b0;
    byte_bus.valid        = 1'b0;
    byte_bus.data_byte    = '0;
    byte_bus.string_start = 1'b0;
    char_bus.ready        = 1'b0;
    build_directed();
    build_random();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() > 0 || byte_bus.valid) @(posedge clk_i);
    while (char_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d characters, %0d end-of-string, %0d faults",
             sent, n_char, n_eos, n_fault);
    $display("Character lengths seen (bit per octet count): %b", len_seen[7:1]);
    if (errors == 0) begin
      $display("PASS utf8_stream_decoder");
    end else begin
      $display("FAIL utf8_stream_decoder");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/u8sd_pkg.sv
rtl/core/u8sd_byte_if.sv
rtl/core/u8sd_char_if.sv
rtl/core/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
